### src/etf_pkg.sv
`default_nettype none
package etf_pkg;

   localparam int VERT_W           = 6;
   localparam int NUM_VERT         = 64;
   localparam int BAL_W            = 8;
   localparam int CSR_IDX_W        = 2;
   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES    = 64;

   typedef struct packed {
      logic [VERT_W-1:0] edge_from;
      logic [VERT_W-1:0] edge_to;
      logic              edge_last;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [VERT_W-1:0] trail_from;
      logic [VERT_W-1:0] trail_to;
      logic [5:0]        edge_index;
      logic              result_last;
   } rsp_type;

   typedef struct packed {
      logic [VERT_W-1:0] from_v;
      logic [VERT_W-1:0] to_v;
   } edge_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIRECTED_MODE = 2'd0,
      CSR_START_VERTEX  = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLD_RD,
      ST_BLD_A,
      ST_BLD_B,
      ST_SCAN,
      ST_PICK,
      ST_W_RD,
      ST_W_HEAD,
      ST_W_POP,
      ST_W_NEXT,
      ST_W_DONE,
      ST_OUT_RD,
      ST_OUT_TR,
      ST_OUT_EA,
      ST_OUT_ED,
      ST_FAIL
   } state_type;

endpackage
`default_nettype wire

### src/eulerian_trail_finder.sv
`default_nettype none
// Channel  Dir  Payload          Handshake
// req      in   edge (req_type)  req_valid / req_ready
// rsp      out  result(rsp_type) rsp_valid / rsp_ready
// csr      in   index + data     csr_valid / csr_ready
//
// Loading accepts one edge per cycle. The beat with edge_last starts a run:
// adjacency lists are built edge by edge, a degree scan covers all 64 vertex
// slots, the walk runs step by step, and the results are emitted one by one,
// all through registered memory reads in the sequencer.
// req_ready is low for the whole run. Reset is synchronous; no memory clear.
module eulerian_trail_finder #(
   parameter int MAX_VERTICES = etf_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = etf_pkg::DEF_MAX_EDGES
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  etf_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output etf_pkg::rsp_type               rsp_data,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [etf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [6:0]                      csr_data
);
   import etf_pkg::*;

   localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int POOL = 2 * MAX_EDGES;
   localparam int SAW  = $clog2(POOL);
   localparam int CW   = $clog2(MAX_EDGES + 1);
   localparam int PW   = $clog2(MAX_EDGES + 2);
   localparam int SKW  = VERT_W + SAW;

   function automatic logic [EAW-1:0] edge_of(input logic [SAW-1:0] s, input logic dir);
      logic [SAW-1:0] t;
      t = dir ? s : (s >> 1);
      return t[EAW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic directed_ff, directed_in;
   logic [6:0] start_ff, start_in;
   logic [CW-1:0] count_ff, count_in;
   logic [EAW-1:0] bld_i_ff, bld_i_in;
   logic op_ff, op_in;
   edge_type edge_ff, edge_in;
   logic [VERT_W-1:0] vaddr_ff, vaddr_in;
   logic [NUM_VERT-1:0] touched_ff, touched_in, hv_ff, hv_in;
   logic [POOL-1:0] used_ff, used_in;
   logic [6:0] scan_v_ff, scan_v_in;
   logic scan_p_ff, scan_p_in;
   logic [VERT_W-1:0] scan_vd_ff, scan_vd_in;
   logic [1:0] np_ff, np_in, nm_ff, nm_in, nodd_ff, nodd_in;
   logic bad_ff, bad_in;
   logic [VERT_W-1:0] pv_ff, pv_in, o0_ff, o0_in, o1_ff, o1_in, last_t_ff, last_t_in;
   logic [VERT_W-1:0] cur_v_ff, cur_v_in;
   logic [SAW-1:0] cur_e_ff, cur_e_in, e_ff, e_in, oslot_ff, oslot_in;
   logic [PW-1:0] sp_ff, sp_in, tn_ff, tn_in;
   logic [CW-1:0] oidx_ff, oidx_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [SAW-1:0] head_mem [NUM_VERT];
   logic [SAW-1:0] head_rd_ff;
   logic head_we;
   logic [VERT_W-1:0] head_waddr, head_raddr;
   logic [SAW-1:0] head_wdata;

   logic [BAL_W-1:0] bal_mem [NUM_VERT];
   logic [BAL_W-1:0] bal_rd_ff;
   logic bal_we;
   logic [VERT_W-1:0] bal_waddr, bal_raddr;
   logic [BAL_W-1:0] bal_wdata;

   logic [SAW:0] next_mem [POOL];
   logic [SAW:0] next_rd_ff;
   logic next_we;
   logic [SAW-1:0] next_waddr, next_raddr;
   logic [SAW:0] next_wdata;

   logic [SKW-1:0] stack_mem [MAX_EDGES+1];
   logic [SKW-1:0] stack_rd_ff;
   logic stack_we;
   logic [CW-1:0] stack_waddr, stack_raddr;
   logic [SKW-1:0] stack_wdata;

   logic [SAW-1:0] trail_mem [MAX_EDGES+1];
   logic [SAW-1:0] trail_rd_ff;
   logic trail_we;
   logic [CW-1:0] trail_waddr, trail_raddr;

   logic es_we;
   logic [EAW-1:0] es_waddr, es_raddr;
   edge_type es_wdata, es_rd;

   logic [CW-1:0] cnt_next;
   logic [VERT_W-1:0] v_sel, s_sel;
   logic [SAW-1:0] slot;
   logic [BAL_W-1:0] bv;
   logic given, pick_fail, rsp_free;
   logic [PW-1:0] sp_dec;

   etf_edge_store #(.MAX_EDGES(MAX_EDGES)) u_edge_store (
      .clock   (clock),
      .wr_en   (es_we),
      .wr_addr (es_waddr),
      .wr_data (es_wdata),
      .rd_addr (es_raddr),
      .rd_data (es_rd)
   );

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= head_mem[head_raddr];
      if (bal_we) begin
         bal_mem[bal_waddr] <= bal_wdata;
      end
      bal_rd_ff <= bal_mem[bal_raddr];
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_rd_ff <= next_mem[next_raddr];
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_rd_ff <= stack_mem[stack_raddr];
      if (trail_we) begin
         trail_mem[trail_waddr] <= cur_e_ff;
      end
      trail_rd_ff <= trail_mem[trail_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         directed_ff  <= 1'b0;
         start_ff     <= 7'h7f;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         directed_ff  <= directed_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bld_i_ff    <= bld_i_in;
      op_ff       <= op_in;
      edge_ff     <= edge_in;
      vaddr_ff    <= vaddr_in;
      touched_ff  <= touched_in;
      hv_ff       <= hv_in;
      used_ff     <= used_in;
      scan_v_ff   <= scan_v_in;
      scan_p_ff   <= scan_p_in;
      scan_vd_ff  <= scan_vd_in;
      np_ff       <= np_in;
      nm_ff       <= nm_in;
      nodd_ff     <= nodd_in;
      bad_ff      <= bad_in;
      pv_ff       <= pv_in;
      o0_ff       <= o0_in;
      o1_ff       <= o1_in;
      last_t_ff   <= last_t_in;
      cur_v_ff    <= cur_v_in;
      cur_e_ff    <= cur_e_in;
      e_ff        <= e_in;
      oslot_ff    <= oslot_in;
      sp_ff       <= sp_in;
      tn_ff       <= tn_in;
      oidx_ff     <= oidx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;
      directed_in = directed_ff;
      start_in = start_ff;
      count_in = count_ff;
      bld_i_in = bld_i_ff;
      op_in = op_ff;
      edge_in = edge_ff;
      vaddr_in = vaddr_ff;
      touched_in = touched_ff;
      hv_in = hv_ff;
      used_in = used_ff;
      scan_v_in = scan_v_ff;
      scan_p_in = scan_p_ff;
      scan_vd_in = scan_vd_ff;
      np_in = np_ff;
      nm_in = nm_ff;
      nodd_in = nodd_ff;
      bad_in = bad_ff;
      pv_in = pv_ff;
      o0_in = o0_ff;
      o1_in = o1_ff;
      last_t_in = last_t_ff;
      cur_v_in = cur_v_ff;
      cur_e_in = cur_e_ff;
      e_in = e_ff;
      oslot_in = oslot_ff;
      sp_in = sp_ff;
      tn_in = tn_ff;
      oidx_in = oidx_ff;
      rsp_data_in = rsp_data_ff;
      rsp_free = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
      bal_we = 1'b0; bal_waddr = '0; bal_wdata = '0; bal_raddr = '0;
      next_we = 1'b0; next_waddr = '0; next_wdata = '0; next_raddr = '0;
      stack_we = 1'b0; stack_waddr = '0; stack_wdata = '0; stack_raddr = '0;
      trail_we = 1'b0; trail_waddr = '0; trail_raddr = '0;
      es_we = 1'b0; es_waddr = count_ff[EAW-1:0]; es_raddr = '0;
      es_wdata.from_v = req_data.edge_from;
      es_wdata.to_v = req_data.edge_to;

      req_ready = (state_ff == ST_IDLE);
      csr_ready = 1'b1;

      cnt_next = count_ff;
      v_sel = '0;
      s_sel = '0;
      slot = '0;
      bv = '0;
      given = !start_ff[6];
      pick_fail = 1'b0;
      sp_dec = sp_ff - PW'(1);

      if (csr_valid) begin
         case (csr_index)
            CSR_DIRECTED_MODE: directed_in = csr_data[0];
            CSR_START_VERTEX:  start_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ((int'(count_ff) < MAX_EDGES) &&
                   (int'(req_data.edge_from) < MAX_VERTICES) &&
                   (int'(req_data.edge_to) < MAX_VERTICES)) begin
                  es_we = 1'b1;
                  cnt_next = count_ff + CW'(1);
               end
               count_in = cnt_next;
               if (req_data.edge_last) begin
                  touched_in = '0;
                  hv_in = '0;
                  used_in = '0;
                  bld_i_in = '0;
                  op_in = 1'b0;
                  state_in = (cnt_next == '0) ? ST_FAIL : ST_BLD_RD;
               end
            end
         end
         ST_BLD_RD: begin
            es_raddr = bld_i_ff;
            state_in = ST_BLD_A;
         end
         ST_BLD_A: begin
            v_sel = op_ff ? edge_ff.to_v : es_rd.from_v;
            if (!op_ff) begin
               edge_in = es_rd;
            end
            vaddr_in = v_sel;
            head_raddr = v_sel;
            bal_raddr = v_sel;
            state_in = ST_BLD_B;
         end
         ST_BLD_B: begin
            slot = directed_ff ? SAW'(bld_i_ff) : SAW'({bld_i_ff, op_ff});
            if (!op_ff || !directed_ff) begin
               next_we = 1'b1;
               next_waddr = slot;
               next_wdata = {hv_ff[vaddr_ff], head_rd_ff};
               head_we = 1'b1;
               head_waddr = vaddr_ff;
               head_wdata = slot;
               hv_in[vaddr_ff] = 1'b1;
            end
            bal_we = 1'b1;
            bal_waddr = vaddr_ff;
            bal_wdata = (touched_ff[vaddr_ff] ? bal_rd_ff : '0) +
                        ((op_ff && directed_ff) ? {BAL_W{1'b1}} : BAL_W'(1));
            touched_in[vaddr_ff] = 1'b1;
            if (!op_ff) begin
               op_in = 1'b1;
               state_in = ST_BLD_A;
            end else begin
               op_in = 1'b0;
               if (CW'(bld_i_ff) + CW'(1) == count_ff) begin
                  scan_v_in = '0;
                  scan_p_in = 1'b0;
                  np_in = '0;
                  nm_in = '0;
                  nodd_in = '0;
                  bad_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  bld_i_in = bld_i_ff + EAW'(1);
                  state_in = ST_BLD_RD;
               end
            end
         end
         ST_SCAN: begin
            bal_raddr = scan_v_ff[VERT_W-1:0];
            scan_vd_in = scan_v_ff[VERT_W-1:0];
            scan_p_in = !scan_v_ff[6];
            if (!scan_v_ff[6]) begin
               scan_v_in = scan_v_ff + 7'd1;
            end else begin
               state_in = ST_PICK;
            end
            if (scan_p_ff) begin
               bv = touched_ff[scan_vd_ff] ? bal_rd_ff : '0;
               if (touched_ff[scan_vd_ff]) begin
                  last_t_in = scan_vd_ff;
               end
               if (directed_ff) begin
                  if ($signed(bv) >= 8'sd2 || $signed(bv) <= -8'sd2) begin
                     bad_in = 1'b1;
                  end
                  if (bv == BAL_W'(1)) begin
                     if (np_ff == 2'd0) begin
                        pv_in = scan_vd_ff;
                     end
                     if (np_ff != 2'd2) begin
                        np_in = np_ff + 2'd1;
                     end
                  end
                  if (bv == {BAL_W{1'b1}} && nm_ff != 2'd2) begin
                     nm_in = nm_ff + 2'd1;
                  end
               end else if (bv[0]) begin
                  if (nodd_ff == 2'd0) begin
                     o0_in = scan_vd_ff;
                  end
                  if (nodd_ff == 2'd1) begin
                     o1_in = scan_vd_ff;
                  end
                  if (nodd_ff != 2'd3) begin
                     nodd_in = nodd_ff + 2'd1;
                  end
               end
            end
         end
         ST_PICK: begin
            if (directed_ff) begin
               pick_fail = bad_ff || (np_ff > 2'd1) || (nm_ff > 2'd1) ||
                           (given && np_ff == 2'd1 && pv_ff != start_ff[VERT_W-1:0]);
               s_sel = given ? start_ff[VERT_W-1:0] : ((np_ff == 2'd1) ? pv_ff : last_t_ff);
            end else begin
               pick_fail = (nodd_ff == 2'd3) ||
                           (given && nodd_ff != 2'd0 && start_ff[VERT_W-1:0] != o0_ff &&
                            !(nodd_ff == 2'd2 && start_ff[VERT_W-1:0] == o1_ff));
               s_sel = given ? start_ff[VERT_W-1:0] : ((nodd_ff != 2'd0) ? o0_ff : last_t_ff);
            end
            if (given && int'(start_ff[VERT_W-1:0]) >= MAX_VERTICES) begin
               pick_fail = 1'b1;
            end
            cur_v_in = s_sel;
            cur_e_in = '0;
            sp_in = PW'(1);
            tn_in = '0;
            state_in = pick_fail ? ST_FAIL : ST_W_RD;
         end
         ST_W_RD: begin
            head_raddr = cur_v_ff;
            state_in = ST_W_HEAD;
         end
         ST_W_HEAD: begin
            if (!hv_ff[cur_v_ff]) begin
               trail_we = 1'b1;
               trail_waddr = tn_ff[CW-1:0];
               tn_in = tn_ff + PW'(1);
               sp_in = sp_dec;
               stack_raddr = sp_ff[CW-1:0] - CW'(2);
               state_in = (sp_ff == PW'(1)) ? ST_W_DONE : ST_W_POP;
            end else begin
               e_in = head_rd_ff;
               next_raddr = head_rd_ff;
               es_raddr = edge_of(head_rd_ff, directed_ff);
               state_in = ST_W_NEXT;
            end
         end
         ST_W_POP: begin
            cur_v_in = stack_rd_ff[SKW-1:SAW];
            cur_e_in = stack_rd_ff[SAW-1:0];
            state_in = ST_W_RD;
         end
         ST_W_NEXT: begin
            head_we = 1'b1;
            head_waddr = cur_v_ff;
            head_wdata = next_rd_ff[SAW-1:0];
            hv_in[cur_v_ff] = next_rd_ff[SAW];
            if (!used_ff[e_ff]) begin
               used_in[e_ff] = 1'b1;
               if (!directed_ff) begin
                  used_in[e_ff ^ SAW'(1)] = 1'b1;
               end
               stack_we = 1'b1;
               stack_waddr = sp_dec[CW-1:0];
               stack_wdata = {cur_v_ff, cur_e_ff};
               sp_in = sp_ff + PW'(1);
               cur_v_in = (!directed_ff && e_ff[0]) ? es_rd.from_v : es_rd.to_v;
               cur_e_in = e_ff;
            end
            state_in = ST_W_RD;
         end
         ST_W_DONE: begin
            oidx_in = tn_ff[CW-1:0] - CW'(2);
            state_in = (tn_ff == PW'(count_ff) + PW'(1)) ? ST_OUT_RD : ST_FAIL;
         end
         ST_OUT_RD: begin
            trail_raddr = oidx_ff;
            state_in = ST_OUT_TR;
         end
         ST_OUT_TR: begin
            oslot_in = trail_rd_ff;
            state_in = ST_OUT_EA;
         end
         ST_OUT_EA: begin
            es_raddr = edge_of(oslot_ff, directed_ff);
            state_in = ST_OUT_ED;
         end
         ST_OUT_ED: begin
            es_raddr = edge_of(oslot_ff, directed_ff);
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = 1'b0;
               if (!directed_ff && oslot_ff[0]) begin
                  rsp_data_in.trail_from = es_rd.to_v;
                  rsp_data_in.trail_to = es_rd.from_v;
               end else begin
                  rsp_data_in.trail_from = es_rd.from_v;
                  rsp_data_in.trail_to = es_rd.to_v;
               end
               rsp_data_in.edge_index = 6'(edge_of(oslot_ff, directed_ff));
               rsp_data_in.result_last = (oidx_ff == '0);
               if (oidx_ff == '0) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  oidx_in = oidx_ff - CW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_FAIL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_data_in.status = 1'b1;
               rsp_data_in.result_last = 1'b1;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

### src/etf_edge_store.sv
`default_nettype none
module etf_edge_store #(
   parameter int MAX_EDGES = etf_pkg::DEF_MAX_EDGES,
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [EAW-1:0]           wr_addr,
   input  etf_pkg::edge_type       wr_data,
   input  wire [EAW-1:0]           rd_addr,
   output etf_pkg::edge_type       rd_data
);
   import etf_pkg::*;

   edge_type mem [MAX_EDGES];
   edge_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### tb/sv/etf_checker.sv
`timescale 1ns / 100ps
module etf_checker
   import etf_pkg::*;
(
   input  wire            clock,
   input  wire            reset,
   input  wire            req_valid,
   input  wire            req_ready,
   input  req_type        req_data,
   input  wire            rsp_valid,
   input  wire            rsp_ready,
   input  rsp_type        rsp_data,
   input  wire            csr_valid,
   input  wire            csr_ready,
   input  wire [1:0]      csr_index,
   input  wire [6:0]      csr_data,
   output int             mismatches,
   output int             trails_owed,
   output int             runs_seen,
   output int             no_trail_runs,
   output int             trail_beats
);

   localparam int POOL = 2 * DEF_MAX_EDGES;

   logic              dir_mode;
   logic signed [6:0] start_cfg;
   edge_type          edge_mem[DEF_MAX_EDGES];
   int                edge_cnt;
   rsp_type           trail_q[$];

   function automatic rsp_type no_trail();
      rsp_type r;
      r             = '0;
      r.status      = 1'b1;
      r.result_last = 1'b1;
      return r;
   endfunction

   task automatic find_trail();
      int      a_from[POOL], a_to[POOL], a_idx[POOL], a_next[POOL], a_mate[POOL];
      bit      a_used[POOL];
      int      head[NUM_VERT], fill[NUM_VERT], bal[NUM_VERT];
      bit      touched[NUM_VERT];
      int      stk_v[DEF_MAX_EDGES+1], stk_e[DEF_MAX_EDGES+1];
      int      order[DEF_MAX_EDGES+1];
      int      slots, s, np, nm, pv, nodd, o0, o1, sp, tn, cur, e, f, t;
      rsp_type r;
      runs_seen++;
      if (edge_cnt == 0) begin
         trail_q.push_back(no_trail());
         no_trail_runs++;
         return;
      end
      for (int v = 0; v < NUM_VERT; v++) begin
         head[v] = -1; fill[v] = 0; bal[v] = 0; touched[v] = 0;
      end
      slots = 0;
      for (int i = 0; i < edge_cnt; i++) begin
         f = edge_mem[i].from_v;
         t = edge_mem[i].to_v;
         touched[f] = 1; touched[t] = 1;
         for (int k = 0; k < (dir_mode ? 1 : 2); k++) begin
            a_from[slots] = k ? t : f;
            a_to[slots]   = k ? f : t;
            a_idx[slots]  = i;
            a_mate[slots] = dir_mode ? -1 : (k ? slots - 1 : slots + 1);
            a_used[slots] = 0;
            a_next[slots] = head[a_from[slots]];
            head[a_from[slots]] = slots;
            fill[a_from[slots]]++;
            slots++;
         end
         if (dir_mode) begin
            bal[f]++; bal[t]--;
         end
      end
      s = start_cfg < 0 ? -1 : int'(start_cfg);
      if (dir_mode) begin
         np = 0; nm = 0; pv = -1;
         for (int v = 0; v < NUM_VERT; v++) begin
            if (bal[v] >= 2 || bal[v] <= -2) s = -2;
            if (bal[v] == 1) begin
               if (np == 0) pv = v;
               np++;
            end else if (bal[v] == -1) nm++;
         end
         if (np > 1 || nm > 1) s = -2;
         if (s >= 0 && np == 1 && pv != s) s = -2;
         if (s == -1) begin
            for (int v = 0; v < NUM_VERT; v++) if (touched[v]) s = v;
            if (np == 1) s = pv;
         end
      end else begin
         nodd = 0; o0 = -1; o1 = -1;
         for (int v = 0; v < NUM_VERT; v++) begin
            if (fill[v] % 2) begin
               if (nodd == 0) o0 = v;
               else if (nodd == 1) o1 = v;
               nodd++;
            end
         end
         if (nodd > 2) s = -2;
         if (s >= 0 && nodd > 0 && s != o0 && s != o1) s = -2;
         if (s == -1) begin
            for (int v = 0; v < NUM_VERT; v++) if (fill[v] != 0) s = v;
            if (nodd > 0) s = o0;
         end
      end
      if (s < 0) begin
         trail_q.push_back(no_trail());
         no_trail_runs++;
         return;
      end
      sp = 1; stk_v[0] = s; stk_e[0] = -1; tn = 0;
      while (sp > 0) begin
         cur = stk_v[sp-1];
         e   = head[cur];
         if (e < 0) begin
            if (tn < DEF_MAX_EDGES + 1) begin
               order[tn] = stk_e[sp-1];
               tn++;
            end
            sp--;
         end else begin
            head[cur] = a_next[e];
            if (!a_used[e]) begin
               a_used[e] = 1;
               if (!dir_mode) a_used[a_mate[e]] = 1;
               if (sp < DEF_MAX_EDGES + 1) begin
                  stk_v[sp] = a_to[e];
                  stk_e[sp] = e;
                  sp++;
               end
            end
         end
      end
      if (tn - 1 != edge_cnt) begin
         trail_q.push_back(no_trail());
         no_trail_runs++;
         return;
      end
      for (int k = 0; k < edge_cnt; k++) begin
         e = order[tn-2-k];
         r.status      = 1'b0;
         r.trail_from  = 6'(a_from[e]);
         r.trail_to    = 6'(a_to[e]);
         r.edge_index  = 6'(a_idx[e]);
         r.result_last = (k == edge_cnt - 1);
         trail_q.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         dir_mode  <= 1'b0;
         start_cfg <= -7'sd1;
         edge_cnt  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DIRECTED_MODE) dir_mode <= csr_data[0];
            else if (csr_index == CSR_START_VERTEX) start_cfg <= csr_data;
         end
         if (req_valid && req_ready) begin
            if (edge_cnt < DEF_MAX_EDGES) begin
               edge_mem[edge_cnt] = {req_data.edge_from, req_data.edge_to};
               edge_cnt++;
            end
            if (req_data.edge_last) begin
               find_trail();
               edge_cnt = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            trail_beats++;
            if (trail_q.size() == 0) begin
               $error("unexpected result beat %p", rsp_data);
               mismatches++;
            end else begin
               exp_r = trail_q.pop_front();
               if (rsp_data.status !== exp_r.status) begin
                  $error("status exp %0d got %0d", exp_r.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.trail_from !== exp_r.trail_from) begin
                  $error("trail_from exp %0d got %0d", exp_r.trail_from,
                         rsp_data.trail_from);
                  mismatches++;
               end
               if (rsp_data.trail_to !== exp_r.trail_to) begin
                  $error("trail_to exp %0d got %0d", exp_r.trail_to, rsp_data.trail_to);
                  mismatches++;
               end
               if (rsp_data.edge_index !== exp_r.edge_index) begin
                  $error("edge_index exp %0d got %0d", exp_r.edge_index,
                         rsp_data.edge_index);
                  mismatches++;
               end
               if (rsp_data.result_last !== exp_r.result_last) begin
                  $error("result_last exp %0d got %0d", exp_r.result_last,
                         rsp_data.result_last);
                  mismatches++;
               end
            end
         end
         trails_owed = trail_q.size();
      end
   end

   initial begin
      mismatches    = 0;
      trails_owed   = 0;
      runs_seen     = 0;
      no_trail_runs = 0;
      trail_beats   = 0;
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import etf_pkg::*;

   localparam int LIMIT = 1_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DIRECTED_MODE;
   logic [6:0] csr_data = '0;

   int mismatches, trails_owed, runs_seen, no_trail_runs, trail_beats;
   int cycles = 0;
   int edges_sent = 0;
   bit idle_on = 1'b1;
   bit hold_off = 1'b0;
   logic signed [6:0] start_now = -7'sd1;
   logic dir_now = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   eulerian_trail_finder dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   etf_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data, .mismatches,
      .trails_owed, .runs_seen, .no_trail_runs, .trail_beats
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      int k;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
            k = 0;
         end else begin
            k = idle_on ? $urandom_range(0, 4) : 0;
            if (k > 0) begin
               rsp_ready <= 1'b0;
               repeat (k) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_edge(input int f, input int t, input bit last);
      int k;
      k = idle_on ? $urandom_range(0, 4) : 0;
      if (k > 0) begin
         req_valid <= 1'b0;
         repeat (k) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{edge_from: f[5:0], edge_to: t[5:0], edge_last: last};
      do @(posedge clock); while (!req_ready);
      edges_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [6:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (trails_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DIRECTED_MODE) dir_now = val[0];
      else start_now = val;
   endtask

   task automatic set_mode(input bit d, input logic [6:0] s);
      write_csr(CSR_DIRECTED_MODE, {6'd0, d});
      write_csr(CSR_START_VERTEX, s);
   endtask

   // closed-or-open walk on a few vertices, sent shuffled and maybe flipped
   task automatic send_walk(input int n);
      int base, span, v, w, fr[$], to[$], j, tmp;
      base = $urandom_range(0, 63);
      span = $urandom_range(2, 8);
      v = (start_now >= 0 && $urandom_range(0, 3) != 0) ? int'(start_now) : base;
      for (int i = 0; i < n; i++) begin
         w = (base + $urandom_range(0, span - 1)) % 64;
         fr.push_back(v); to.push_back(w);
         v = w;
      end
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = fr[i]; fr[i] = fr[j]; fr[j] = tmp;
         tmp = to[i]; to[i] = to[j]; to[j] = tmp;
      end
      for (int i = 0; i < n; i++) begin
         if (!dir_now && $urandom_range(0, 1)) send_edge(to[i], fr[i], i == n - 1);
         else send_edge(fr[i], to[i], i == n - 1);
      end
   endtask

   initial begin
      int n, sel;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_mode(1'b0, -7'sd1);
      send_edge(63, 63, 1);
      send_edge(0, 63, 1);
      send_edge(0, 1, 0); send_edge(0, 2, 0); send_edge(0, 3, 1);
      send_edge(5, 6, 0); send_edge(6, 5, 1);
      set_mode(1'b1, -7'sd1);
      send_edge(0, 63, 0); send_edge(63, 0, 0); send_edge(0, 42, 1);
      send_edge(1, 2, 0); send_edge(1, 3, 1);
      set_mode(1'b1, 7'sd63);
      send_edge(10, 11, 1);
      send_edge(63, 21, 1);
      set_mode(1'b0, 7'sd5);
      send_edge(5, 5, 0); send_edge(5, 7, 0); send_edge(7, 5, 1);
      send_edge(8, 9, 1);
      set_mode(1'b0, 7'h40);
      for (int i = 0; i < 66; i++) send_edge(i % 64, (i + 1) % 64, i == 65);

      for (int ph = 0; ph < 8; ph++) begin
         idle_on = (ph != 4);
         if (ph < 2) set_mode(ph[0], -7'sd1);
         else if ($urandom_range(0, 1)) set_mode(1'($urandom_range(0, 1)), -7'sd1);
         else set_mode(1'($urandom_range(0, 1)), 7'($urandom_range(0, 63)));
         if (ph == 2) hold_off = 1'b1;
         for (int it = 0; it < 40; it++) begin
            sel = $urandom_range(0, 9);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 64)
                                             : $urandom_range(1, 10);
            if (sel < 8) send_walk(n);
            else begin
               for (int i = 0; i < n; i++)
                  send_edge($urandom_range(0, 63), $urandom_range(0, 63), i == n - 1);
            end
            if (edges_sent > 100 + ph * 25) break;
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (trails_owed != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("runs: %0d searched, %0d with no trail; %0d result beats; %0d edges",
               runs_seen, no_trail_runs, trail_beats, edges_sent);
      $display("both modes, fixed and automatic starts, full store, long stall");
      if (mismatches == 0 && trails_owed == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

endmodule

### files.f
src/etf_pkg.sv
src/etf_edge_store.sv
src/eulerian_trail_finder.sv
tb/sv/etf_checker.sv
tb/sv/tb_top.sv
